### rtl/clx_pkg.sv
// Shared types and constants for the C-style lexer.
package clx_pkg;

    // Token kinds as carried on the output tuser field.
    localparam logic [1:0] KIND_EOT    = 2'd0;
    localparam logic [1:0] KIND_IDENT  = 2'd1;
    localparam logic [1:0] KIND_STRING = 2'd2;
    localparam logic [1:0] KIND_SINGLE = 2'd3;

    // Character codes the lexer reacts to.
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    // Output fields are fixed at 16 bits whatever the internal offset width.
    localparam int unsigned OUT_BITS = 16;

    // Token queue between the scanner and the output side.
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    // Scanner modes, one-hot.
    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_SLASH   = 6'b000010,
        MODE_IDENT   = 6'b000100,
        MODE_STRING  = 6'b001000,
        MODE_ESC     = 6'b010000,
        MODE_COMMENT = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [1:0]          token_kind;
        logic [7:0]          token_char;
        logic [OUT_BITS-1:0] start_offset;
        logic [OUT_BITS-1:0] text_length;
        logic                last;
    } tok_t;

    // Up to two tokens written into the queue in one cycle.
    typedef struct packed {
        logic wr0;
        logic wr1;
        tok_t tok0;
        tok_t tok1;
    } push_t;

endpackage

### rtl/c_style_lexer.sv
// Top level of the streaming C-style lexer: byte scanner plus token queue.
//
// Usage: source bytes enter on the s_axis channel, one byte per item, and
// tokens leave on the m_axis channel, one token per item. Byte 0 ends a
// text: it flushes any pending identifier, string or held slash and then
// yields an end-of-text token; the next byte starts a new text at offset 0.
// Whitespace and line comments produce no token. A byte that closes a
// pending token and is itself a token yields two items; m_axis_tlast marks
// the last token caused by one input byte.
// Latency: a token is offered on m_axis in the cycle after the byte that
// completes it is accepted, if no earlier token waits. Throughput: one byte
// per cycle. The scanner writes up to two tokens a cycle into a four-entry
// queue and the output side drains one per cycle; s_axis_tready drops only
// while fewer than two queue entries are free, so a stalled receiver backs
// up into the input after the queue fills, and no token is lost or repeated.
// Reset: rst_n clears the scanner to idle at offset 0 and empties the
// queue. Offsets count internally in OFFSET_BITS bits and saturate; the
// 16-bit output offsets and lengths saturate at 65535.
module c_style_lexer
    import clx_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_in[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // token_char[7:0], start_offset[23:8],
                                        // text_length[39:24]
    output logic [1:0]  m_axis_tuser,   // token_kind[1:0]
    output logic        m_axis_tlast    // last token caused by one byte
);

    push_t push;
    logic  space_ok;
    tok_t  head;

    // Front: classifies bytes, tracks the lexer mode and offsets.
    clx_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .space_ok (space_ok),
        .push     (push)
    );

    // Back: queues the tokens and hands them out one per cycle while the receiver is ready.
    clx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .head      (head)
    );

    assign s_axis_tready = space_ok;
    assign m_axis_tdata  = {head.text_length, head.start_offset, head.token_char};
    assign m_axis_tuser  = head.token_kind;
    assign m_axis_tlast  = head.last;

endmodule

### rtl/clx_front.sv
// Byte scanner: classifies each byte and forms up to two tokens per byte.
module clx_front
    import clx_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       space_ok,
    output push_t      push
);

    localparam int unsigned WIDE = (OFFSET_BITS > OUT_BITS) ? OFFSET_BITS : OUT_BITS;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] ts_reg, ts_next;

    logic                   accept;
    logic                   is_alpha, is_digit, is_space, is_nul;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] span;

    logic                   idle_emit;
    tok_t                   idle_tok;
    mode_t                  idle_mode;
    logic [OFFSET_BITS-1:0] idle_ts;

    logic                   pre_valid, post_valid;
    tok_t                   pre_tok, post_tok;

    function automatic logic [OUT_BITS-1:0] sat16(input logic [OFFSET_BITS-1:0] v);
        logic [WIDE-1:0] w;
        begin
            w = WIDE'(v);
            sat16 = (w > WIDE'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : w[OUT_BITS-1:0];
        end
    endfunction

    function automatic tok_t mk_tok(input logic [1:0] kind, input logic [7:0] ch,
                                    input logic [OFFSET_BITS-1:0] start,
                                    input logic [OFFSET_BITS-1:0] len);
        tok_t t;
        begin
            t.token_kind   = kind;
            t.token_char   = ch;
            t.start_offset = sat16(start);
            t.text_length  = sat16(len);
            t.last         = 1'b0;
            mk_tok = t;
        end
    endfunction

    assign accept = in_valid && space_ok;

    always_comb
    begin
        is_alpha = (in_byte inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z]});
        is_digit = (in_byte inside {[CH_DIGIT_0:CH_DIGIT_9]});
        is_space = (in_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR});
        is_nul   = (in_byte == CH_NUL);
        pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + OFFSET_BITS'(1);
        span     = (pos_reg >= ts_reg) ? pos_reg - ts_reg : '0;
    end

    // What a byte does when no token is pending.
    always_comb
    begin
        idle_emit = 1'b0;
        idle_tok  = mk_tok(KIND_EOT, CH_NUL, pos_reg, '0);
        idle_mode = MODE_IDLE;
        idle_ts   = ts_reg;
        if (is_nul)
        begin
            idle_emit = 1'b1;
        end
        else if (is_space)
        begin
            idle_emit = 1'b0;
        end
        else if (is_alpha)
        begin
            idle_mode = MODE_IDENT;
            idle_ts   = pos_reg;
        end
        else if (in_byte == CH_QUOTE)
        begin
            idle_mode = MODE_STRING;
            idle_ts   = pos_inc;
        end
        else if (in_byte == CH_SLASH)
        begin
            idle_mode = MODE_SLASH;
            idle_ts   = pos_reg;
        end
        else
        begin
            idle_emit = 1'b1;
            idle_tok  = mk_tok(KIND_SINGLE, in_byte, pos_reg, OFFSET_BITS'(1));
        end
    end

    always_comb
    begin
        pre_valid  = 1'b0;
        pre_tok    = mk_tok(KIND_STRING, CH_NUL, ts_reg, span);
        post_valid = 1'b0;
        post_tok   = idle_tok;
        mode_next  = mode_reg;
        ts_next    = ts_reg;
        case (mode_reg)
            MODE_SLASH:
            begin
                if (in_byte == CH_SLASH || in_byte == CH_STAR)
                begin
                    mode_next = MODE_COMMENT;
                end
                else
                begin
                    // A lone slash is a divide token ahead of whatever this byte is.
                    pre_valid  = 1'b1;
                    pre_tok    = mk_tok(KIND_SINGLE, CH_SLASH, ts_reg, OFFSET_BITS'(1));
                    post_valid = idle_emit;
                    mode_next  = idle_mode;
                    ts_next    = idle_ts;
                end
            end
            MODE_IDENT:
            begin
                if (!(is_alpha || is_digit || in_byte == CH_UNDERSCORE))
                begin
                    pre_valid  = 1'b1;
                    pre_tok    = mk_tok(KIND_IDENT, CH_NUL, ts_reg, span);
                    post_valid = idle_emit;
                    mode_next  = idle_mode;
                    ts_next    = idle_ts;
                end
            end
            MODE_STRING, MODE_ESC:
            begin
                if (is_nul)
                begin
                    pre_valid  = 1'b1;
                    post_valid = 1'b1;
                    post_tok   = mk_tok(KIND_EOT, CH_NUL, pos_reg, '0);
                end
                else if (mode_reg == MODE_ESC)
                begin
                    mode_next = MODE_STRING;
                end
                else if (in_byte == CH_BSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    pre_valid = 1'b1;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_COMMENT:
            begin
                if (is_nul)
                begin
                    post_valid = 1'b1;
                    post_tok   = mk_tok(KIND_EOT, CH_NUL, pos_reg, '0);
                end
                else if (in_byte == CH_LF || in_byte == CH_CR)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                post_valid = idle_emit;
                mode_next  = idle_mode;
                ts_next    = idle_ts;
            end
        endcase

        // The end of text puts the scanner back to its reset state.
        if (is_nul)
        begin
            mode_next = MODE_IDLE;
            pos_next  = '0;
            ts_next   = '0;
        end
        else
        begin
            pos_next = pos_inc;
        end
    end

    // Pack the tokens so the first one always lands in slot zero.
    always_comb
    begin
        push.wr0       = accept && (pre_valid || post_valid);
        push.wr1       = accept && pre_valid && post_valid;
        push.tok0      = pre_valid ? pre_tok : post_tok;
        push.tok0.last = !(pre_valid && post_valid);
        push.tok1      = post_tok;
        push.tok1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= '0;
            ts_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            ts_reg   <= ts_next;
        end
    end

    a_nul_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_byte == CH_NUL) |=> (mode_reg == MODE_IDLE && pos_reg == '0))
        else $error("end of text did not reset the scanner");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.wr1 |-> (push.wr0 && !push.tok0.last))
        else $error("second token written without a first");

endmodule

### rtl/clx_back.sv
// Token queue and output side: buffers tokens and presents them one per cycle while out_ready is high.
module clx_back
    import clx_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  space_ok,
    output logic  out_valid,
    input  logic  out_ready,
    output tok_t  head
);

    tok_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_p1;
    logic              pop;
    logic [1:0]        push_n;

    assign space_ok  = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign push_n    = {1'b0, push.wr0} + {1'b0, push.wr1};
    assign wr_ptr_p1 = wr_ptr_reg + QPTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.wr0)
        begin
            mem_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.wr1)
        begin
            mem_reg[wr_ptr_p1] <= push.tok1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.wr0 |-> (count_reg <= QCNT_W'(QDEPTH - 2)))
        else $error("token queue written without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("token queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule
